/* rtl/assert_macros.svh */
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AIOC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define AIOC_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define AIOC_ASSERT(label, prop)
`define AIOC_NEVER(label, expr)
`endif

`endif

/* rtl/aioc_pkg.sv */
`timescale 1ns / 1ps

package aioc_pkg;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_FRAME = 2'd2,
		OP_IRQEN = 2'd3
	} op_t;

	typedef struct packed {
		op_t        mode;
		logic [3:0] offset;
		logic [7:0] write_data;
		logic [7:0] coin_start_port;
		logic [7:0] player_port;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_request;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC1,
		ST_CALC2,
		ST_FIN
	} state_t;

	// one-shot trigger codes
	localparam logic [1:0] TRIG_IDLE  = 2'd0;
	localparam logic [1:0] TRIG_FRESH = 2'd1;
	localparam logic [1:0] TRIG_AGED  = 2'd2;

	// chip mode byte values
	localparam logic [7:0] CHIP_MODE_A    = 8'd1;
	localparam logic [7:0] CHIP_MODE_B    = 8'd3;
	localparam logic [7:0] CHIP_MODE_TEST = 8'd5;

	// read offsets in the credit modes
	localparam logic [3:0] OFF_COIN   = 4'd0;
	localparam logic [3:0] OFF_START  = 4'd1;
	localparam logic [3:0] OFF_TENS   = 4'd2;
	localparam logic [3:0] OFF_ONES   = 4'd3;
	localparam logic [3:0] OFF_PLAY_L = 4'd4;
	localparam logic [3:0] OFF_PLAY_H = 4'd5;
	localparam logic [3:0] OFF_ZERO_A = 4'd6;
	localparam logic [3:0] OFF_ZERO_B = 4'd7;

	localparam logic [7:0] CREDIT_MAX = 8'd255;

	function automatic logic [2:0] ratio_num(input logic [2:0] r);
		unique case (r)
			3'd0: return 3'd1;
			3'd1: return 3'd2;
			3'd2: return 3'd3;
			3'd3: return 3'd6;
			3'd4: return 3'd1;
			3'd5: return 3'd3;
			3'd6: return 3'd1;
			3'd7: return 3'd2;
			default: return 3'd1;
		endcase
	endfunction

	function automatic logic [1:0] ratio_den(input logic [2:0] r);
		unique case (r)
			3'd0, 3'd1, 3'd2, 3'd3: return 2'd1;
			3'd4, 3'd5: return 2'd2;
			3'd6, 3'd7: return 2'd3;
			default: return 2'd1;
		endcase
	endfunction

	function automatic logic [3:0] test_nibble(input logic [3:0] off);
		unique case (off)
			4'd1: return 4'd8;
			4'd2: return 4'd4;
			4'd3: return 4'd6;
			4'd4: return 4'd14;
			4'd5: return 4'd13;
			4'd6: return 4'd9;
			4'd7: return 4'd13;
			default: return 4'd0;
		endcase
	endfunction

endpackage

/* rtl/aioc_ram.sv */
`timescale 1ns / 1ps

module aioc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/aioc_scale.sv */
`timescale 1ns / 1ps

module aioc_scale import aioc_pkg::*; (
	input  logic       clk,
	input  logic [7:0] credit,
	input  logic [2:0] ratio,
	output logic [7:0] tens,
	output logic [3:0] ones
);

	logic [10:0] prod_s1;
	logic [1:0]  den_s1;
	logic [10:0] scaled_s2;
	logic [10:0] scaled_s3;
	logic [7:0]  tens_s3;
	logic [22:0] third;
	logic [22:0] tenth;
	logic [10:0] times_ten;
	logic [10:0] rem;

	// divide by three as multiply by 2731 / 8192, exact for products up to 1530
	assign third = 23'(prod_s1) * 23'(12'd2731);
	// divide by ten as multiply by 3277 / 32768
	assign tenth = 23'(scaled_s2) * 23'(12'd3277);

	always_ff @(posedge clk) begin
		prod_s1 <= 11'(credit) * 11'(ratio_num(ratio));
		den_s1  <= ratio_den(ratio);
		unique case (den_s1)
			2'd2:    scaled_s2 <= prod_s1 >> 1;
			2'd3:    scaled_s2 <= 11'(third[22:13]);
			default: scaled_s2 <= prod_s1;
		endcase
		scaled_s3 <= scaled_s2;
		tens_s3   <= tenth[22:15];
	end

	assign times_ten = {tens_s3, 3'b000} + {2'b00, tens_s3, 1'b0};
	assign rem       = scaled_s3 - times_ten;
	assign tens      = tens_s3;
	assign ones      = rem[3:0];

endmodule

/* rtl/arcade_io_credit_controller.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Credit and input controller behind a 16-byte register store. Each transfer on
// the input channel carries one bus access (store write, store read, frame tick
// or interrupt enable) and produces exactly one result transfer. An access steps
// from its input transfer through a registered read of the store memory (ST_READ),
// the credit scaling pipeline (ratio multiply, divide by the ratio denominator,
// split into tens and ones) settling in ST_CALC1 and ST_CALC2, and ST_FIN, which
// updates credits and triggers and loads the output register holding the result.
// The block returns to idle once that register is loaded and takes the next access
// even if the result is still waiting; its own result then stalls in ST_FIN until
// the first is taken.
// The coin ratio register may be written at any time the block is idle.
module arcade_io_credit_controller import aioc_pkg::*; #(
	parameter int STORE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [2:0] cfg_data
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [AW-1:0] MODE_ENTRY = AW'(8 % STORE_DEPTH);

	state_t state_q, state_n;

	in_item_t  item_q;
	out_item_t out_q;
	logic      out_valid_q;
	logic [7:0] data_q;
	logic [7:0] mode_q;
	logic [2:0] ratio_q;
	logic [STORE_DEPTH-1:0] written_q;

	logic [7:0] credit_q, credit_n, credit_mid;
	logic [1:0] coin_q, coin_n;
	logic [1:0] start1_q, start1_n;
	logic [1:0] start2_q, start2_n;
	logic [1:0] fire_q, fire_n;
	logic       irq_en_q, irq_en_n;
	logic [7:0] rd;
	logic       irq;
	logic [3:0] nib;

	logic          in_xfer;
	logic          store_we;
	logic [7:0]    ram_rdata;
	logic [7:0]    tens;
	logic [3:0]    ones;
	logic [1:0]    den;
	logic          load;
	logic [AW-1:0] item_addr;
	logic          any_fresh;
	logic          test_read;

	assign in_xfer   = in_valid && in_ready;
	assign store_we  = in_xfer && (in_item.mode == OP_WRITE);
	assign item_addr = item_q.offset[AW-1:0];
	assign cfg_ready = 1'b1;
	assign den       = ratio_den(ratio_q);

	aioc_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(in_item.offset[AW-1:0]),
		.wdata(in_item.write_data),
		.raddr(in_item.offset[AW-1:0]),
		.rdata(ram_rdata)
	);

	aioc_scale u_scale (
		.clk   (clk),
		.credit(credit_q),
		.ratio (ratio_q),
		.tens  (tens),
		.ones  (ones)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		in_ready = 1'b0;
		load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_n = ST_READ;
				end
			end
			ST_READ:  state_n = ST_CALC1;
			ST_CALC1: state_n = ST_CALC2;
			ST_CALC2: state_n = ST_FIN;
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					load    = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// access outcome and state update, applied when the result is loaded
	always_comb begin
		credit_n   = credit_q;
		credit_mid = credit_q;
		coin_n     = coin_q;
		start1_n   = start1_q;
		start2_n   = start2_q;
		fire_n     = fire_q;
		irq_en_n   = irq_en_q;
		rd         = 8'd0;
		irq        = 1'b0;
		nib        = 4'd0;
		unique case (item_q.mode)
			OP_WRITE: ;
			OP_READ: begin
				if (mode_q == CHIP_MODE_A || mode_q == CHIP_MODE_B) begin
					unique case (item_q.offset)
						OFF_COIN: begin
							nib = item_q.coin_start_port[3:0];
							if (nib[0]) begin
								if (coin_q == TRIG_IDLE) begin
									if (credit_q != CREDIT_MAX) begin
										credit_n = credit_q + 8'd1;
									end
									coin_n = TRIG_FRESH;
								end
								if (coin_n != TRIG_FRESH) begin
									nib[0] = 1'b0;
								end
							end else begin
								coin_n = TRIG_IDLE;
							end
							rd = {4'd0, nib};
						end
						OFF_START: begin
							nib = item_q.coin_start_port[7:4];
							if (nib[0]) begin
								if (start1_q == TRIG_IDLE && credit_q >= {6'd0, den}) begin
									credit_mid = credit_q - {6'd0, den};
									start1_n   = TRIG_FRESH;
								end
								if (start1_n != TRIG_FRESH) begin
									nib[0] = 1'b0;
								end
							end else begin
								start1_n = TRIG_IDLE;
							end
							credit_n = credit_mid;
							// two-player start costs twice the denominator
							if (nib[1]) begin
								if (start2_q == TRIG_IDLE &&
										credit_mid >= {5'd0, den, 1'b0}) begin
									credit_n = credit_mid - {5'd0, den, 1'b0};
									start2_n = TRIG_FRESH;
								end
								if (start2_n != TRIG_FRESH) begin
									nib[1] = 1'b0;
								end
							end else begin
								start2_n = TRIG_IDLE;
							end
							rd = {4'd0, nib};
						end
						OFF_TENS:   rd = tens;
						OFF_ONES:   rd = {4'd0, ones};
						OFF_PLAY_L: rd = {4'd0, item_q.player_port[3:0]};
						OFF_PLAY_H: begin
							nib = item_q.player_port[7:4];
							if (nib[1]) begin
								if (fire_q == TRIG_IDLE) begin
									fire_n = TRIG_FRESH;
								end
								if (fire_n == TRIG_FRESH) begin
									nib[0] = 1'b1;
								end
							end else begin
								fire_n = TRIG_IDLE;
							end
							rd = {4'd0, nib};
						end
						OFF_ZERO_A, OFF_ZERO_B: rd = 8'd0;
						default: rd = data_q;
					endcase
				end else if (mode_q == CHIP_MODE_TEST) begin
					credit_n = 8'd0;
					if (item_q.offset >= 4'd1 && item_q.offset <= 4'd7) begin
						rd = {4'd0, test_nibble(item_q.offset)};
					end else begin
						rd = data_q;
					end
				end else begin
					rd = data_q;
				end
			end
			OP_FRAME: begin
				if (coin_q == TRIG_FRESH)   coin_n   = TRIG_AGED;
				if (start1_q == TRIG_FRESH) start1_n = TRIG_AGED;
				if (start2_q == TRIG_FRESH) start2_n = TRIG_AGED;
				if (fire_q == TRIG_FRESH)   fire_n   = TRIG_AGED;
				irq = irq_en_q;
			end
			OP_IRQEN: irq_en_n = (item_q.offset != 4'd0);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q    <= 8'd0;
			coin_q      <= TRIG_IDLE;
			start1_q    <= TRIG_IDLE;
			start2_q    <= TRIG_IDLE;
			fire_q      <= TRIG_IDLE;
			irq_en_q    <= 1'b0;
			ratio_q     <= 3'd0;
			mode_q      <= 8'd0;
			written_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ratio_q <= cfg_data;
			end
			if (store_we) begin
				written_q[in_item.offset[AW-1:0]] <= 1'b1;
				if (in_item.offset[AW-1:0] == MODE_ENTRY) begin
					mode_q <= in_item.write_data;
				end
			end
			if (load) begin
				credit_q <= credit_n;
				coin_q   <= coin_n;
				start1_q <= start1_n;
				start2_q <= start2_n;
				fire_q   <= fire_n;
				irq_en_q <= irq_en_n;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_q <= in_item;
		end
		// entries never written read as zero
		if (state_q == ST_READ) begin
			data_q <= written_q[item_addr] ? ram_rdata : 8'd0;
		end
		if (load) begin
			out_q.read_data   <= rd;
			out_q.irq_request <= irq;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign any_fresh = (coin_q == TRIG_FRESH) || (start1_q == TRIG_FRESH) ||
		(start2_q == TRIG_FRESH) || (fire_q == TRIG_FRESH);
	assign test_read = (item_q.mode == OP_READ) && (mode_q == CHIP_MODE_TEST);

	`AIOC_ASSERT(a_one_in_flight, in_xfer |=> !in_ready)
	`AIOC_ASSERT(a_tick_ages, (load && item_q.mode == OP_FRAME) |=> !any_fresh)
	`AIOC_ASSERT(a_test_clears, (load && test_read) |=> (credit_q == 8'd0))
	`AIOC_NEVER(a_irq_only_tick, load && irq && item_q.mode != OP_FRAME)

endmodule

/* tb/sv/arcade_io_credit_controller_test.sv */
`timescale 1ns / 1ps

module arcade_io_credit_controller_test import aioc_pkg::*; ();

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 150;
	localparam int RATIO_NUM [8] = '{1, 2, 3, 6, 1, 3, 1, 2};
	localparam int RATIO_DEN [8] = '{1, 1, 1, 1, 2, 2, 3, 3};
	localparam bit [7:0] TEST_NIBBLES [7] = '{8'd8, 8'd4, 8'd6, 8'd14, 8'd13, 8'd9, 8'd13};
	localparam bit [2:0] RATIO_ORDER [8] = '{3'd0, 3'd7, 3'd3, 3'd4, 3'd6, 3'd1, 3'd5, 3'd2};

	class credit_io_scoreboard;
		bit [7:0] store [16];
		bit [7:0] credits;
		bit [1:0] coin_trig, start_one_trig, start_two_trig, fire_trig;
		bit irq_on;
		bit [2:0] ratio;
		out_item_t expected_results [$];
		int errors, accepted, results, ceiling_hits, test_reads, start_takes;

		function int pending();
			return expected_results.size();
		endfunction

		function void take_start(inout bit [7:0] v, input int b, inout bit [1:0] trig,
				input int cost);
			if (v[b]) begin
				if (trig == TRIG_IDLE && credits >= cost) begin
					credits = credits - 8'(cost);
					trig = TRIG_FRESH;
					start_takes++;
				end
				if (trig != TRIG_FRESH)
					v[b] = 1'b0;
			end else begin
				trig = TRIG_IDLE;
			end
		endfunction

		function bit [7:0] read_access(bit [3:0] off, bit [7:0] cs, bit [7:0] pl);
			bit [7:0] chip_mode;
			bit [7:0] v;
			int unsigned scaled;
			chip_mode = store[8];
			scaled = credits * RATIO_NUM[ratio] / RATIO_DEN[ratio];
			if (chip_mode == CHIP_MODE_A || chip_mode == CHIP_MODE_B) begin
				case (off)
					OFF_COIN: begin
						v = {4'b0, cs[3:0]};
						if (v[0]) begin
							if (coin_trig == TRIG_IDLE) begin
								if (credits == CREDIT_MAX)
									ceiling_hits++;
								else
									credits++;
								coin_trig = TRIG_FRESH;
							end
							if (coin_trig != TRIG_FRESH)
								v[0] = 1'b0;
						end else begin
							coin_trig = TRIG_IDLE;
						end
						return v;
					end
					OFF_START: begin
						v = {4'b0, cs[7:4]};
						take_start(v, 0, start_one_trig, RATIO_DEN[ratio]);
						take_start(v, 1, start_two_trig, 2 * RATIO_DEN[ratio]);
						return v;
					end
					OFF_TENS: return 8'(scaled / 10);
					OFF_ONES: return 8'(scaled % 10);
					OFF_PLAY_L: return {4'b0, pl[3:0]};
					OFF_PLAY_H: begin
						v = {4'b0, pl[7:4]};
						if (v[1]) begin
							if (fire_trig == TRIG_IDLE)
								fire_trig = TRIG_FRESH;
							if (fire_trig == TRIG_FRESH)
								v[0] = 1'b1;
						end else begin
							fire_trig = TRIG_IDLE;
						end
						return v;
					end
					OFF_ZERO_A, OFF_ZERO_B: return 8'd0;
					default: return store[off];
				endcase
			end
			if (chip_mode == CHIP_MODE_TEST) begin
				credits = 8'd0;
				test_reads++;
				if (off >= 1 && off <= 7)
					return TEST_NIBBLES[off - 1];
			end
			return store[off];
		endfunction

		function void note_access(in_item_t it);
			out_item_t want;
			want = '0;
			accepted++;
			case (it.mode)
				OP_WRITE: store[it.offset] = it.write_data;
				OP_READ: want.read_data = read_access(it.offset, it.coin_start_port,
						it.player_port);
				OP_FRAME: begin
					if (start_one_trig == TRIG_FRESH) start_one_trig = TRIG_AGED;
					if (start_two_trig == TRIG_FRESH) start_two_trig = TRIG_AGED;
					if (fire_trig == TRIG_FRESH) fire_trig = TRIG_AGED;
					if (coin_trig == TRIG_FRESH) coin_trig = TRIG_AGED;
					want.irq_request = irq_on;
				end
				default: irq_on = (it.offset != 4'd0);
			endcase
			expected_results.push_back(want);
		endfunction

		function void mismatch(string what, int unsigned want, int unsigned got);
			if (errors < 10)
				$display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
			errors++;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			results++;
			if (expected_results.size() == 0) begin
				mismatch("unexpected result transfer", 0, got);
				return;
			end
			want = expected_results.pop_front();
			if (got.read_data !== want.read_data)
				mismatch("read_data", want.read_data, got.read_data);
			if (got.irq_request !== want.irq_request)
				mismatch("irq_request", want.irq_request, got.irq_request);
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [2:0] cfg_data;

	credit_io_scoreboard sb;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	bit hold_pending = 1'b0;
	bit coin_level = 1'b0;
	int cycle_count = 0;

	arcade_io_credit_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_result(out_item);
	end

	function automatic int gap_len();
		int r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// result side: random stalls, plus one long hold-off on request
	initial begin : receiver
		int n;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_ready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
			end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				n = gap_len();
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	function automatic in_item_t access(op_t m, bit [3:0] off, bit [7:0] wd, bit [7:0] cs,
			bit [7:0] pl);
		in_item_t it;
		it.mode = m;
		it.offset = off;
		it.write_data = wd;
		it.coin_start_port = cs;
		it.player_port = pl;
		return it;
	endfunction

	function automatic in_item_t rand_access(bit coin_storm);
		in_item_t it;
		int r;
		it = access(OP_READ, 4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom),
				8'($urandom));
		r = $urandom_range(0, 99);
		if (coin_storm) begin
			// press and release in turn so credits climb to the ceiling
			if (r < 80) begin
				coin_level = ~coin_level;
				it.offset = OFF_COIN;
				it.coin_start_port[0] = coin_level;
			end else if (r < 88) begin
				it.offset = OFF_TENS;
			end else if (r < 96) begin
				it.offset = OFF_ONES;
			end else begin
				it.mode = OP_FRAME;
			end
		end else if (r < 10) begin
			it.mode = OP_WRITE;
			if ($urandom_range(0, 2) == 0) begin
				it.offset = 4'd8;
				r = $urandom_range(0, 99);
				if (r < 40)
					it.write_data = CHIP_MODE_A;
				else if (r < 70)
					it.write_data = CHIP_MODE_B;
				else if (r < 85)
					it.write_data = CHIP_MODE_TEST;
			end
		end else if (r < 18) begin
			it.mode = OP_FRAME;
		end else if (r < 23) begin
			it.mode = OP_IRQEN;
			if ($urandom_range(0, 1) == 0)
				it.offset = 4'd0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 25)
				it.offset = OFF_COIN;
			else if (r < 45)
				it.offset = OFF_START;
			else if (r < 55)
				it.offset = OFF_TENS;
			else if (r < 65)
				it.offset = OFF_ONES;
			else if (r < 80)
				it.offset = OFF_PLAY_H;
		end
		return it;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_access(input in_item_t it);
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_access(it);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		int n;
		if (!sender_idles || $urandom_range(0, 2) != 0)
			return;
		n = gap_len();
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic step(op_t m, bit [3:0] off, bit [7:0] wd, bit [7:0] cs, bit [7:0] pl);
		send_access(access(m, off, wd, cs, pl));
		sender_gap();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic set_ratio(input bit [2:0] r);
		cfg_data <= r;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.ratio = r;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int p, k, count;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_ratio(RATIO_ORDER[0]);

		// mode byte still zero: reads echo the store
		step(OP_READ, 4'd0, 8'h00, 8'hff, 8'hff);
		step(OP_IRQEN, 4'd5, 8'h00, 8'h00, 8'h00);
		step(OP_FRAME, 4'd0, 8'h00, 8'h00, 8'h00);
		step(OP_WRITE, 4'd8, CHIP_MODE_A, 8'h00, 8'h00);
		// coin one-shot: fresh, still fresh, aged, released, pressed again
		step(OP_READ, OFF_COIN, 8'h00, 8'h0f, 8'h00);
		step(OP_READ, OFF_COIN, 8'h00, 8'h0f, 8'h00);
		step(OP_FRAME, 4'd0, 8'h00, 8'h00, 8'h00);
		step(OP_READ, OFF_COIN, 8'h00, 8'h0f, 8'h00);
		step(OP_READ, OFF_COIN, 8'h00, 8'h00, 8'h00);
		step(OP_READ, OFF_COIN, 8'h00, 8'hff, 8'hff);
		step(OP_READ, OFF_TENS, 8'h00, 8'h00, 8'h00);
		step(OP_READ, OFF_ONES, 8'h00, 8'h00, 8'h00);
		// both starts with two credits: one player takes, two players short
		step(OP_READ, OFF_START, 8'h00, 8'h30, 8'h00);
		step(OP_READ, OFF_PLAY_L, 8'h00, 8'h00, 8'hff);
		step(OP_READ, OFF_PLAY_H, 8'h00, 8'h00, 8'ha0);
		step(OP_READ, OFF_PLAY_H, 8'h00, 8'h00, 8'hf0);
		step(OP_READ, OFF_ZERO_B, 8'h00, 8'hff, 8'hff);
		step(OP_WRITE, 4'd15, 8'hff, 8'h00, 8'h00);
		step(OP_READ, 4'd15, 8'h00, 8'h00, 8'h00);
		step(OP_IRQEN, 4'd0, 8'hff, 8'h00, 8'h00);
		step(OP_FRAME, 4'd0, 8'h00, 8'h00, 8'h00);
		step(OP_WRITE, 4'd8, CHIP_MODE_TEST, 8'h00, 8'h00);
		step(OP_READ, 4'd1, 8'h00, 8'h00, 8'h00);
		step(OP_READ, 4'd7, 8'h00, 8'h00, 8'h00);
		step(OP_READ, 4'd0, 8'h00, 8'h00, 8'h00);
		step(OP_WRITE, 4'd8, CHIP_MODE_B, 8'h00, 8'h00);

		for (p = 1; p < 8; p++) begin
			drain();
			set_ratio(RATIO_ORDER[p]);
			sender_idles = (p != 4);
			receiver_idles = (p != 4);
			count = (p == 1) ? 760 : 140;
			if (p == 2)
				hold_pending = 1'b1;
			for (k = 0; k < count; k++) begin
				send_access(rand_access(p == 1));
				// keep offering back to back while the result side holds off
				if (!(p == 2 && k < 60))
					sender_gap();
				if ($urandom_range(0, 199) == 0)
					drain();
			end
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		$display("%0d accesses and %0d results over all eight coin ratios", sb.accepted,
				sb.results);
		$display("credit ceiling reached %0d times, %0d test-mode reads, %0d start deductions",
				sb.ceiling_hits, sb.test_reads, sb.start_takes);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d errors", sb.errors);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
